### src/iolat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iolat_pkg: shared definitions for the I/O latency tracker
// Field widths, item and result codes, and the divide-by-1000 unit's
// constants and status type.
// ----------------------------------------------------------------------------
package iolat_pkg;

	localparam int TAG_COUNT_DEF = 1024;

	localparam int KIND_W   = 2;
	localparam int TAG_W    = 10;
	localparam int TIME_W   = 64;
	localparam int PID_W    = 32;
	localparam int NAME_W   = 64;
	localparam int SECTOR_W = 64;
	localparam int LEN_W    = 32;
	localparam int DEV_W    = 32;
	localparam int OP_W     = 8;
	localparam int BKT_W    = 6;
	localparam int RKIND_W  = 3;
	localparam int LAT_W    = 55;
	localparam int COUNT_W  = 64;

	localparam int HIST_DEPTH = 64;
	localparam int BUCKET_MAX = 63;

	localparam logic [LAT_W-1:0] THRESH_RESET = LAT_W'(1000);

	// divide-by-1000 unit: restoring division, several quotient bits per cycle
	localparam int DIVISOR           = 1000;
	localparam int DIV_REM_W         = 10;
	localparam int DIV_BITS_PER_STEP = 8;
	localparam int DIV_STEPS         = TIME_W / DIV_BITS_PER_STEP;
	localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

	typedef enum logic [KIND_W-1:0] {
		KIND_ISSUE    = 2'd0,
		KIND_COMPLETE = 2'd1,
		KIND_READ     = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [RKIND_W-1:0] {
		RES_ISSUE     = 3'd0,
		RES_UNMATCHED = 3'd1,
		RES_FAST      = 3'd2,
		RES_SLOW      = 3'd3,
		RES_BUCKET    = 3'd4
	} result_kind_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

### src/iolat_div1000.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iolat_div1000: iterative divide by 1000
// Restoring division of a 64-bit value, eight quotient bits per cycle.
// The quotient bits shift into the low end of the dividend register.
// ----------------------------------------------------------------------------
module iolat_div1000 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [iolat_pkg::TIME_W-1:0]   dividend,
	output logic [iolat_pkg::LAT_W-1:0]    quotient,
	output iolat_pkg::div_status_t         status
);
	import iolat_pkg::*;

	localparam logic [DIV_REM_W:0] DIVISOR_X = (DIV_REM_W + 1)'(DIVISOR);

	logic [TIME_W-1:0]    work_q;
	logic [DIV_REM_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [TIME_W-1:0]    work_nxt;
	logic [DIV_REM_W-1:0] rem_nxt;

	always_comb begin
		logic [DIV_REM_W:0]         trial;
		logic [DIV_REM_W-1:0]       r;
		logic [DIV_BITS_PER_STEP-1:0] qbits;
		r     = rem_q;
		qbits = '0;
		trial = '0;
		for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
			trial = {r, work_q[TIME_W-1-i]};
			if (trial >= DIVISOR_X) begin
				trial = trial - DIVISOR_X;
				qbits[DIV_BITS_PER_STEP-1-i] = 1'b1;
			end
			r = trial[DIV_REM_W-1:0];
		end
		rem_nxt  = r;
		work_nxt = {work_q[TIME_W-DIV_BITS_PER_STEP-1:0], qbits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign quotient = work_q[LAT_W-1:0];
	assign status   = '{busy: busy_q, done: done_q};

endmodule

### src/io_latency_tracker_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_latency_tracker_histogram: block I/O latency tracker with log2 histogram
// Keeps in-flight requests in a tag-indexed table memory, measures latency
// in microseconds on completion and counts it into a 64-bucket histogram.
// ----------------------------------------------------------------------------
//
// Channel   Handshake            Moves
// --------  -------------------  ------------------------------------------
// cfg       cfg_valid/cfg_ready  slow_threshold_us write (always ready)
// in        in_valid/in_stall    one request: issue, completion or read
// out       out_valid/out_stall  one result per request (none for kind 3)
//
// Path from accept to S_FINISH: issue S_SLOT; bucket read S_HREAD; completion
// S_SLOT, S_TREAD, S_TCHK, on a match also S_DIV, S_LOG, S_HREAD. The matched
// path is set by the divide by 1000 (eight quotient bits per cycle, 8 steps)
// plus a table read and a histogram read-modify-write, each registered. After
// reset the table valid bits are cleared by a pass over all TAG_COUNT entries
// with in_stall high; the histogram uses per-bucket valid flops instead.
// A result waiting on out_stall does not block the next request from being
// accepted; only the final load of the output register waits.
// ----------------------------------------------------------------------------
module io_latency_tracker_histogram #(
	parameter int TAG_COUNT = iolat_pkg::TAG_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [iolat_pkg::LAT_W-1:0]     slow_threshold_us,
	// requests
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [iolat_pkg::KIND_W-1:0]    kind,
	input  logic [iolat_pkg::TAG_W-1:0]     tag,
	input  logic [iolat_pkg::TIME_W-1:0]    now_ns,
	input  logic [iolat_pkg::PID_W-1:0]     owner_pid,
	input  logic [iolat_pkg::NAME_W-1:0]    name_low,
	input  logic [iolat_pkg::NAME_W-1:0]    name_high,
	input  logic [iolat_pkg::SECTOR_W-1:0]  start_sector,
	input  logic [iolat_pkg::LEN_W-1:0]     length_bytes,
	input  logic [iolat_pkg::DEV_W-1:0]     device_number,
	input  logic [iolat_pkg::OP_W-1:0]      request_op,
	input  logic [iolat_pkg::BKT_W-1:0]     bucket_index,
	// results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [iolat_pkg::RKIND_W-1:0]   result_kind,
	output logic [iolat_pkg::LAT_W-1:0]     latency_us,
	output logic [iolat_pkg::BKT_W-1:0]     bucket,
	output logic [iolat_pkg::COUNT_W-1:0]   bucket_count,
	output logic [iolat_pkg::PID_W-1:0]     event_pid,
	output logic [iolat_pkg::NAME_W-1:0]    event_name_low,
	output logic [iolat_pkg::NAME_W-1:0]    event_name_high,
	output logic [iolat_pkg::SECTOR_W-1:0]  event_sector,
	output logic [iolat_pkg::LEN_W-1:0]     event_bytes,
	output logic [iolat_pkg::DEV_W-1:0]     event_device,
	output logic                            is_write
);
	import iolat_pkg::*;

	// Slot = tag mod TAG_COUNT by reciprocal multiply. With a (2*TAG_W+1)-bit
	// reciprocal the estimated quotient is exact for every 10-bit tag, and it
	// is zero whenever TAG_COUNT is not below the tag range.
	localparam int SLOT_W = $clog2(TAG_COUNT);
	localparam int CNT_W  = $clog2(TAG_COUNT + 1);
	localparam int RCP_SH = 2 * TAG_W;
	localparam int RCP_W  = RCP_SH + 1;
	localparam int REM_W  = (SLOT_W > TAG_W) ? SLOT_W : TAG_W;
	localparam int PRD1_W = TAG_W + RCP_W;
	localparam int PRD2_W = TAG_W + CNT_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((1 << RCP_SH) + TAG_COUNT - 1) / TAG_COUNT);

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] start;
		logic [PID_W-1:0]  pid;
		logic [NAME_W-1:0] name_lo;
		logic [NAME_W-1:0] name_hi;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SLOT,
		S_TREAD,
		S_TCHK,
		S_DIV,
		S_LOG,
		S_HREAD,
		S_FINISH
	} state_t;

	function automatic logic [BKT_W:0] floor_log2(input logic [TIME_W-1:0] v_in);
		logic [TIME_W-1:0] v;
		logic [BKT_W:0]    r;
		v = v_in;
		r = '0;
		if (v > TIME_W'(64'hffff_ffff)) begin
			v = v >> 32;
			r = r + (BKT_W + 1)'(32);
		end
		if (v > TIME_W'(64'h0000_ffff)) begin
			v = v >> 16;
			r = r + (BKT_W + 1)'(16);
		end
		if (v > TIME_W'(64'h0000_00ff)) begin
			v = v >> 8;
			r = r + (BKT_W + 1)'(8);
		end
		if (v > TIME_W'(64'h0000_000f)) begin
			v = v >> 4;
			r = r + (BKT_W + 1)'(4);
		end
		if (v > TIME_W'(64'h0000_0003)) begin
			v = v >> 2;
			r = r + (BKT_W + 1)'(2);
		end
		r = r + (BKT_W + 1)'(v[1]);
		return r;
	endfunction

	// FSM and registered outputs
	state_t               state_q;
	logic [SLOT_W-1:0]    clr_idx_q;
	logic [HIST_DEPTH-1:0] hist_vld_q;
	logic                 out_valid_q;
	logic [RKIND_W-1:0]   res_kind_q;
	logic [LAT_W-1:0]     res_lat_q;
	logic [BKT_W-1:0]     res_bkt_q;
	logic [COUNT_W-1:0]   res_cnt_q;
	logic [PID_W-1:0]     res_pid_q;
	logic [NAME_W-1:0]    res_nlo_q;
	logic [NAME_W-1:0]    res_nhi_q;
	logic [SECTOR_W-1:0]  res_sector_q;
	logic [LEN_W-1:0]     res_bytes_q;
	logic [DEV_W-1:0]     res_dev_q;
	logic                 res_wr_q;

	// request working registers
	kind_t                kind_q;
	logic [TAG_W-1:0]     tag_q;
	logic [TAG_W-1:0]     quot_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [TIME_W-1:0]    now_q;
	logic [PID_W-1:0]     pid_q;
	logic [NAME_W-1:0]    nlo_q;
	logic [NAME_W-1:0]    nhi_q;
	logic [SECTOR_W-1:0]  sector_q;
	logic [LEN_W-1:0]     bytes_q;
	logic [DEV_W-1:0]     dev_q;
	logic [OP_W-1:0]      op_q;
	logic [BKT_W-1:0]     bucket_q;
	logic [LAT_W-1:0]     lat_q;
	logic                 hit_q;
	logic [LAT_W-1:0]     thr_q;

	// memories
	entry_t               tbl_mem [TAG_COUNT];
	entry_t               tbl_rd_q;
	logic [COUNT_W-1:0]   hist_mem [HIST_DEPTH];
	logic [COUNT_W-1:0]   hist_rd_q;

	logic                 in_accept;
	logic                 out_free;
	logic                 finish;
	logic                 tbl_we;
	logic                 tbl_re;
	logic [SLOT_W-1:0]    tbl_waddr;
	entry_t               tbl_wdata;
	logic                 hist_we;
	logic                 hist_re;
	logic [COUNT_W-1:0]   hist_count;
	logic [COUNT_W-1:0]   cnt_inc;
	logic [PRD1_W-1:0]    rcp_prod;
	logic [PRD2_W-1:0]    back_prod;
	logic [REM_W-1:0]     slot_full;
	logic                 div_start;
	logic [TIME_W-1:0]    div_dividend;
	logic [LAT_W-1:0]     div_quot;
	div_status_t          div_status;
	logic [TIME_W-1:0]    lat_plus;
	logic [BKT_W:0]       log_raw;
	logic [BKT_W-1:0]     log_bkt;
	logic                 is_slow;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign finish    = (state_q == S_FINISH) && out_free;

	// slot arithmetic: quotient estimate at accept, remainder in the next cycle (S_SLOT)
	assign rcp_prod  = PRD1_W'(tag) * PRD1_W'(RECIP);
	assign back_prod = PRD2_W'(quot_q) * PRD2_W'(TAG_COUNT);
	assign slot_full = REM_W'(tag_q) - back_prod[REM_W-1:0];

	// latency and bucket
	assign div_start    = (state_q == S_TCHK) && tbl_rd_q.valid;
	assign div_dividend = now_q - tbl_rd_q.start;
	assign lat_plus     = TIME_W'(div_quot) + TIME_W'(1);
	assign log_raw      = floor_log2(lat_plus);
	assign log_bkt      = (log_raw > (BKT_W + 1)'(BUCKET_MAX)) ? BKT_W'(BUCKET_MAX)
	                                                           : log_raw[BKT_W-1:0];

	// histogram count: a bucket never written reads as zero
	assign hist_count = hist_vld_q[bucket_q] ? hist_rd_q : '0;
	assign cnt_inc    = hist_count + COUNT_W'(1);
	assign is_slow    = (lat_q >= thr_q);

	assign tbl_re  = (state_q == S_TREAD);
	assign hist_re = (state_q == S_HREAD);
	assign hist_we = finish && (kind_q == KIND_COMPLETE) && hit_q;

	// table write port: clearing pass, issue record, or drop on match
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = slot_q;
		tbl_wdata = '0;
		if (state_q == S_CLEAR) begin
			tbl_we    = 1'b1;
			tbl_waddr = clr_idx_q;
		end else if (finish && (kind_q == KIND_ISSUE)) begin
			tbl_we    = 1'b1;
			tbl_wdata = '{valid: 1'b1, start: now_q, pid: pid_q,
			              name_lo: nlo_q, name_hi: nhi_q};
		end else if (finish && (kind_q == KIND_COMPLETE) && hit_q) begin
			tbl_we          = 1'b1;
			tbl_wdata       = tbl_rd_q;
			tbl_wdata.valid = 1'b0;
		end
	end

	// table memory: one write, one registered read. One request is in flight
	// at a time, so a read never overlaps a pending write to the same entry.
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rd_q <= tbl_mem[slot_q];
		end
	end

	// histogram memory: read in S_HREAD, write back in S_FINISH
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[bucket_q] <= cnt_inc;
		end
		if (hist_re) begin
			hist_rd_q <= hist_mem[bucket_q];
		end
	end

	iolat_div1000 u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.quotient (div_quot),
		.status   (div_status)
	);

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= slow_threshold_us;
		end
	end

	// request working registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_q   <= kind_t'(kind);
			tag_q    <= tag;
			quot_q   <= rcp_prod[RCP_SH +: TAG_W];
			now_q    <= now_ns;
			pid_q    <= owner_pid;
			nlo_q    <= name_low;
			nhi_q    <= name_high;
			sector_q <= start_sector;
			bytes_q  <= length_bytes;
			dev_q    <= device_number;
			op_q     <= request_op;
			bucket_q <= bucket_index;
		end
		if (state_q == S_SLOT) begin
			slot_q <= slot_full[SLOT_W-1:0];
		end
		if (state_q == S_TCHK) begin
			hit_q <= tbl_rd_q.valid;
		end
		if (state_q == S_LOG) begin
			lat_q    <= div_quot;
			bucket_q <= log_bkt;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_idx_q    <= '0;
			hist_vld_q   <= '0;
			out_valid_q  <= 1'b0;
			res_kind_q   <= '0;
			res_lat_q    <= '0;
			res_bkt_q    <= '0;
			res_cnt_q    <= '0;
			res_pid_q    <= '0;
			res_nlo_q    <= '0;
			res_nhi_q    <= '0;
			res_sector_q <= '0;
			res_bytes_q  <= '0;
			res_dev_q    <= '0;
			res_wr_q     <= 1'b0;
		end else begin
			// drop the result once taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + SLOT_W'(1);
					if (clr_idx_q == SLOT_W'(TAG_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						case (kind_t'(kind))
							KIND_ISSUE:    state_q <= S_SLOT;
							KIND_COMPLETE: state_q <= S_SLOT;
							KIND_READ:     state_q <= S_HREAD;
							default:       state_q <= S_IDLE;
						endcase
					end
				end
				S_SLOT: begin
					state_q <= (kind_q == KIND_ISSUE) ? S_FINISH : S_TREAD;
				end
				S_TREAD: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					state_q <= tbl_rd_q.valid ? S_DIV : S_FINISH;
				end
				S_DIV: begin
					if (div_status.done && !div_status.busy) begin
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					state_q <= S_HREAD;
				end
				S_HREAD: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						state_q      <= S_IDLE;
						out_valid_q  <= 1'b1;
						res_kind_q   <= RES_ISSUE;
						res_lat_q    <= '0;
						res_bkt_q    <= '0;
						res_cnt_q    <= '0;
						res_pid_q    <= '0;
						res_nlo_q    <= '0;
						res_nhi_q    <= '0;
						res_sector_q <= '0;
						res_bytes_q  <= '0;
						res_dev_q    <= '0;
						res_wr_q     <= 1'b0;
						if (kind_q == KIND_READ) begin
							res_kind_q <= RES_BUCKET;
							res_bkt_q  <= bucket_q;
							res_cnt_q  <= hist_count;
						end else if (kind_q == KIND_COMPLETE) begin
							if (!hit_q) begin
								res_kind_q <= RES_UNMATCHED;
							end else begin
								hist_vld_q[bucket_q] <= 1'b1;
								res_lat_q  <= lat_q;
								res_bkt_q  <= bucket_q;
								res_cnt_q  <= cnt_inc;
								res_pid_q  <= tbl_rd_q.pid;
								res_nlo_q  <= tbl_rd_q.name_lo;
								res_nhi_q  <= tbl_rd_q.name_hi;
								if (is_slow) begin
									res_kind_q   <= RES_SLOW;
									res_sector_q <= sector_q;
									res_bytes_q  <= bytes_q;
									res_dev_q    <= dev_q;
									res_wr_q     <= (op_q != '0);
								end else begin
									res_kind_q <= RES_FAST;
								end
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign result_kind     = res_kind_q;
	assign latency_us      = res_lat_q;
	assign bucket          = res_bkt_q;
	assign bucket_count    = res_cnt_q;
	assign event_pid       = res_pid_q;
	assign event_name_low  = res_nlo_q;
	assign event_name_high = res_nhi_q;
	assign event_sector    = res_sector_q;
	assign event_bytes     = res_bytes_q;
	assign event_device    = res_dev_q;
	assign is_write        = res_wr_q;

endmodule

### src/iolat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iolat_checker: port-level checks for the I/O latency tracker
// Watches the result channel for held results and for payload fields that
// the result kind does not use.
// ----------------------------------------------------------------------------
module iolat_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [iolat_pkg::RKIND_W-1:0]   result_kind,
	input logic [iolat_pkg::LAT_W-1:0]     latency_us,
	input logic [iolat_pkg::COUNT_W-1:0]   bucket_count,
	input logic [iolat_pkg::PID_W-1:0]     event_pid,
	input logic [iolat_pkg::SECTOR_W-1:0]  event_sector,
	input logic [iolat_pkg::LEN_W-1:0]     event_bytes,
	input logic [iolat_pkg::DEV_W-1:0]     event_device,
	input logic                            is_write
);
	import iolat_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind)
			&& $stable(latency_us) && $stable(bucket_count))
		else $error("stalled result changed");

	// issue and unmatched results carry no latency, count or submitter
	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == RES_ISSUE || result_kind == RES_UNMATCHED)
			|-> latency_us == '0 && bucket_count == '0 && event_pid == '0)
		else $error("unmatched or issue result has payload");

	// pass-through fields appear on slow events only
	a_pass_slow_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != RES_SLOW
			|-> event_sector == '0 && event_bytes == '0 && event_device == '0
				&& !is_write)
		else $error("pass-through fields set outside a slow event");

	// a bucket read has no latency and no submitter
	a_read_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == RES_BUCKET |-> latency_us == '0 && event_pid == '0)
		else $error("bucket read carries completion fields");

endmodule

bind io_latency_tracker_histogram iolat_checker u_iolat_checker (.*);
